>>> sv/tlrq_pkg.sv
// Shared types and constants for the three-level ready-queue scheduler.
// No dependencies.
package tlrq_pkg;

  localparam int unsigned PW = 6;  // process index field width
  localparam int unsigned TW = 7;  // class threshold register width
  localparam int unsigned KW = 2;  // command kind width
  localparam int unsigned NQ = 3;  // number of ready queues
  localparam int unsigned QW = 2;  // queue code width

  localparam logic [KW-1:0] KIND_READY   = 2'd0;
  localparam logic [KW-1:0] KIND_UNREADY = 2'd1;
  localparam logic [KW-1:0] KIND_ROTATE  = 2'd2;
  localparam logic [KW-1:0] KIND_PICK    = 2'd3;

  localparam logic [QW-1:0] Q_TASK   = 2'd0;
  localparam logic [QW-1:0] Q_SERVER = 2'd1;
  localparam logic [QW-1:0] Q_USER   = 2'd2;

  localparam logic [1:0] REG_FIRST_SERVER = 2'd0;
  localparam logic [1:0] REG_FIRST_USER   = 2'd1;
  localparam logic [1:0] REG_IDLE         = 2'd2;

  localparam logic [TW-1:0] FIRST_SERVER_RST = 7'd8;
  localparam logic [TW-1:0] FIRST_USER_RST   = 7'd10;
  localparam logic [PW-1:0] IDLE_RST         = 6'd0;

  typedef struct packed {
    logic latch;
    logic rdy_link;
    logic rdy_self;
    logic un_read;
    logic un_resolve;
    logic walk_step;
    logic rot_read;
    logic rot_finish;
    logic pick;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rdy_ok;
    logic un_ok;
    logic un_is_head;
    logic un_need_pick;
    logic walk_done;
    logic user_empty;
  } sts_t;

endpackage

>>> sv/tlrq_ctrl.sv
// Command sequencer of the ready-queue scheduler.
// Depends on tlrq_pkg (command/status structs, kind codes).
module tlrq_ctrl import tlrq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [KW-1:0] kind_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  sts_t          sts_i,
  output cmd_t          cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDY1 = 4'd1;
  localparam logic [3:0] S_RDY2 = 4'd2;
  localparam logic [3:0] S_UN0  = 4'd3;
  localparam logic [3:0] S_UN1  = 4'd4;
  localparam logic [3:0] S_WALK = 4'd5;
  localparam logic [3:0] S_ROT0 = 4'd6;
  localparam logic [3:0] S_ROT1 = 4'd7;
  localparam logic [3:0] S_PICK = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          case (kind_i)
            KIND_READY:   state_d = S_RDY1;
            KIND_UNREADY: state_d = S_UN0;
            KIND_ROTATE:  state_d = S_ROT0;
            default:      state_d = S_PICK;
          endcase
        end
      end
      S_RDY1: begin
        if (sts_i.rdy_ok) begin
          cmd_o.rdy_link = 1'b1;
          state_d        = S_RDY2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RDY2: begin
        cmd_o.rdy_self = 1'b1;
        state_d        = S_DONE;
      end
      S_UN0: begin
        if (sts_i.un_ok) begin
          cmd_o.un_read = 1'b1;
          state_d       = S_UN1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_UN1: begin
        cmd_o.un_resolve = 1'b1;
        if (!sts_i.un_is_head) begin
          state_d = S_WALK;
        end else if (sts_i.un_need_pick) begin
          state_d = S_PICK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_DONE;
        end
      end
      S_ROT0: begin
        if (sts_i.user_empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rot_read = 1'b1;
          state_d        = S_ROT1;
        end
      end
      S_ROT1: begin
        cmd_o.rot_finish = 1'b1;
        state_d          = S_PICK;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> sv/tlrq_dpath.sv
// Queue datapath: link and queue-code memories, heads, tails, in-queue bits,
// current/billed process and the result register. Depends on tlrq_pkg.
module tlrq_dpath import tlrq_pkg::*; #(
  parameter int unsigned PROC_SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  output sts_t          sts_o,
  input  logic [PW-1:0] proc_index_i,
  input  logic [TW-1:0] first_server_i,
  input  logic [TW-1:0] first_user_i,
  input  logic [PW-1:0] idle_i,
  output logic [PW-1:0] running_proc_o,
  output logic [PW-1:0] billed_proc_o,
  output logic          was_queued_o
);

  localparam int unsigned AW = $clog2(PROC_SLOTS);
  localparam int unsigned LW = $clog2(PROC_SLOTS + 1);
  localparam logic [LW-1:0] NO_PROC = LW'(PROC_SLOTS);

  logic [LW-1:0] link_mem [PROC_SLOTS];
  logic [QW-1:0] qof_mem  [PROC_SLOTS];

  logic [LW-1:0]         head_q [NQ];
  logic [LW-1:0]         tail_q [NQ];
  logic [PROC_SLOTS-1:0] inq_q;
  logic [PW-1:0]         cur_q, bill_q;
  logic [PW-1:0]         p_q;
  logic [QW-1:0]         q_q;
  logic [LW-1:0]         x_q, lp_q;
  logic                  removed_q;
  logic [LW-1:0]         lk_rd_q;
  logic [QW-1:0]         qof_rd_q;
  logic [PW-1:0]         run_q, billo_q;
  logic                  wq_q;

  logic [AW-1:0] p_a;
  logic [LW-1:0] p_l;
  logic          p_ok;
  logic [QW-1:0] cls;
  logic          y_hit;
  logic          lk_we;
  logic [AW-1:0] lk_wa, lk_ra;
  logic [LW-1:0] lk_wd;

  assign p_a   = AW'(p_q);
  assign p_l   = LW'(p_q);
  assign p_ok  = 32'(p_q) < 32'(PROC_SLOTS);
  assign y_hit = (lk_rd_q == p_l);

  always_comb begin
    if ({1'b0, p_q} < first_server_i) begin
      cls = Q_TASK;
    end else if ({1'b0, p_q} < first_user_i) begin
      cls = Q_SERVER;
    end else begin
      cls = Q_USER;
    end
  end

  always_comb begin
    sts_o.rdy_ok       = p_ok && !inq_q[p_a];
    sts_o.un_ok        = p_ok && inq_q[p_a];
    sts_o.un_is_head   = (head_q[qof_rd_q] == p_l);
    sts_o.un_need_pick = (qof_rd_q != Q_TASK) || (p_q == cur_q);
    sts_o.walk_done    = y_hit || (lk_rd_q >= NO_PROC);
    sts_o.user_empty   = (head_q[Q_USER] == NO_PROC);
  end

  always_comb begin
    lk_we = 1'b0;
    lk_wa = p_a;
    lk_wd = NO_PROC;
    lk_ra = p_a;
    if (cmd_i.rdy_link && head_q[cls] != NO_PROC) begin
      lk_we = 1'b1;
      lk_wa = AW'(tail_q[cls]);
      lk_wd = p_l;
    end
    if (cmd_i.rdy_self) begin
      lk_we = 1'b1;
    end
    if (cmd_i.un_resolve) begin
      lk_ra = AW'(head_q[qof_rd_q]);
    end
    if (cmd_i.walk_step) begin
      lk_ra = AW'(lk_rd_q);
      if (y_hit) begin
        lk_we = 1'b1;
        lk_wa = AW'(x_q);
        lk_wd = lp_q;
      end
    end
    if (cmd_i.rot_read) begin
      lk_we = 1'b1;
      lk_wa = AW'(tail_q[Q_USER]);
      lk_wd = head_q[Q_USER];
      lk_ra = AW'(head_q[Q_USER]);
    end
    if (cmd_i.rot_finish) begin
      lk_we = 1'b1;
      lk_wa = AW'(x_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      link_mem[lk_wa] <= lk_wd;
    end
    lk_rd_q <= link_mem[lk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rdy_link) begin
      qof_mem[p_a] <= cls;
    end
    qof_rd_q <= qof_mem[p_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NQ; i++) begin
        head_q[i] <= NO_PROC;
        tail_q[i] <= NO_PROC;
      end
      inq_q  <= '0;
      cur_q  <= IDLE_RST;
      bill_q <= IDLE_RST;
    end else begin
      if (cmd_i.rdy_link) begin
        if (head_q[cls] == NO_PROC) begin
          head_q[cls] <= p_l;
          if (cls == Q_TASK) begin
            cur_q <= p_q;
          end
        end
        tail_q[cls] <= p_l;
        inq_q[p_a]  <= 1'b1;
      end
      if (cmd_i.un_read) begin
        inq_q[p_a] <= 1'b0;
      end
      if (cmd_i.un_resolve && head_q[qof_rd_q] == p_l) begin
        head_q[qof_rd_q] <= lk_rd_q;
        if (lk_rd_q == NO_PROC) begin
          tail_q[qof_rd_q] <= NO_PROC;
        end
      end
      if (cmd_i.walk_step && y_hit && tail_q[q_q] == p_l) begin
        tail_q[q_q] <= x_q;
      end
      if (cmd_i.rot_finish) begin
        head_q[Q_USER] <= (lk_rd_q == NO_PROC) ? x_q : lk_rd_q;
        tail_q[Q_USER] <= x_q;
      end
      if (cmd_i.pick) begin
        if (head_q[Q_TASK] != NO_PROC) begin
          cur_q <= PW'(head_q[Q_TASK]);
        end else if (head_q[Q_SERVER] != NO_PROC) begin
          cur_q <= PW'(head_q[Q_SERVER]);
        end else if (head_q[Q_USER] != NO_PROC) begin
          cur_q  <= PW'(head_q[Q_USER]);
          bill_q <= PW'(head_q[Q_USER]);
        end else begin
          cur_q  <= idle_i;
          bill_q <= idle_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      p_q       <= proc_index_i;
      removed_q <= 1'b0;
    end
    if (cmd_i.un_read) begin
      removed_q <= 1'b1;
    end
    if (cmd_i.un_resolve) begin
      lp_q <= lk_rd_q;
      q_q  <= qof_rd_q;
      x_q  <= head_q[qof_rd_q];
    end
    if (cmd_i.walk_step && !y_hit) begin
      x_q <= lk_rd_q;
    end
    if (cmd_i.rot_read) begin
      x_q <= head_q[Q_USER];
    end
    if (cmd_i.out_load) begin
      run_q   <= cur_q;
      billo_q <= bill_q;
      wq_q    <= removed_q;
    end
  end

  assign running_proc_o = run_q;
  assign billed_proc_o  = billo_q;
  assign was_queued_o   = wq_q;

endmodule

>>> sv/three_level_ready_queue_scheduler.sv
// Three-level ready-queue scheduler; depends on tlrq_pkg, tlrq_ctrl, tlrq_dpath.
// An unready that removes a queue head may repick; one that does not walks the queue
// behind the head, one link read per cycle. Ignored ready/unready and an empty rotate
// go straight to the result.
// One item at a time; the next is taken in the cycle after the result is loaded.
// Reset: queues empty, current and billed process 0, thresholds 8 and 10.
module three_level_ready_queue_scheduler import tlrq_pkg::*; #(
  parameter int unsigned PROC_SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [KW-1:0] kind_i,
  input  logic [PW-1:0] proc_index_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [PW-1:0] running_proc_o,
  output logic [PW-1:0] billed_proc_o,
  output logic          was_queued_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [TW-1:0] fs_q, fu_q;
  logic [PW-1:0] idle_q;
  logic          wr_en;
  cmd_t          cmd;
  sts_t          sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= FIRST_SERVER_RST;
      fu_q   <= FIRST_USER_RST;
      idle_q <= IDLE_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_FIRST_SERVER: fs_q   <= pwdata[TW-1:0];
        REG_FIRST_USER:   fu_q   <= pwdata[TW-1:0];
        REG_IDLE:         idle_q <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FIRST_SERVER: prdata = 32'(fs_q);
      REG_FIRST_USER:   prdata = 32'(fu_q);
      REG_IDLE:         prdata = 32'(idle_q);
      default:          prdata = '0;
    endcase
  end

  tlrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tlrq_dpath #(
    .PROC_SLOTS (PROC_SLOTS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .proc_index_i   (proc_index_i),
    .first_server_i (fs_q),
    .first_user_i   (fu_q),
    .idle_i         (idle_q),
    .running_proc_o (running_proc_o),
    .billed_proc_o  (billed_proc_o),
    .was_queued_o   (was_queued_o)
  );

endmodule

>>> verif/scheduler_checker.sv
// Checker for the three-level ready-queue scheduler: mirrors the queues and
// registers from the observed channels and compares every result item.
// Depends on tlrq_pkg.
module scheduler_checker import tlrq_pkg::*; #(
  parameter int unsigned PROC_SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic [KW-1:0] kind_i,
  input  logic [PW-1:0] proc_index_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  logic [PW-1:0] running_proc_i,
  input  logic [PW-1:0] billed_proc_i,
  input  logic          was_queued_i,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic          pready,
  output int            fails_o,
  output int            due_o,
  output int            checked_o
);

  localparam logic [PW:0] NO_SLOT = (PW+1)'(PROC_SLOTS);

  typedef struct packed {
    logic [PW-1:0] running;
    logic [PW-1:0] billed;
    logic          removed;
  } outcome_t;

  logic [PW:0]   link [PROC_SLOTS];
  logic          queued [PROC_SLOTS];
  logic [QW-1:0] home_queue [PROC_SLOTS];
  logic [PW:0]   head [NQ];
  logic [PW:0]   tail [NQ];
  logic [PW-1:0] running;
  logic [PW-1:0] billed;
  logic [TW-1:0] first_server;
  logic [TW-1:0] first_user;
  logic [PW-1:0] idle_proc;
  outcome_t      due_outcomes [$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fails_o++;
  endtask

  task automatic clear_tables();
    for (int i = 0; i < PROC_SLOTS; i++) begin
      link[i] = '0;
      queued[i] = 1'b0;
      home_queue[i] = Q_TASK;
    end
    for (int q = 0; q < NQ; q++) begin
      head[q] = NO_SLOT;
      tail[q] = NO_SLOT;
    end
    first_server = FIRST_SERVER_RST;
    first_user = FIRST_USER_RST;
    idle_proc = IDLE_RST;
    running = IDLE_RST;
    billed = IDLE_RST;
    due_outcomes.delete();
    fails_o = 0;
    due_o = 0;
    checked_o = 0;
  endtask

  function automatic logic [QW-1:0] class_of_proc(input logic [PW-1:0] p);
    if ({1'b0, p} < first_server) return Q_TASK;
    if ({1'b0, p} < first_user) return Q_SERVER;
    return Q_USER;
  endfunction

  function automatic void pick_next();
    if (head[Q_TASK] != NO_SLOT) begin
      running = head[Q_TASK][PW-1:0];
    end else if (head[Q_SERVER] != NO_SLOT) begin
      running = head[Q_SERVER][PW-1:0];
    end else if (head[Q_USER] != NO_SLOT) begin
      running = head[Q_USER][PW-1:0];
      billed = running;
    end else begin
      running = idle_proc;
      billed = idle_proc;
    end
  endfunction

  function automatic void make_ready(input logic [PW-1:0] p);
    logic [QW-1:0] q;
    if (!queued[p]) begin
      q = class_of_proc(p);
      if (head[q] != NO_SLOT) begin
        link[tail[q][PW-1:0]] = {1'b0, p};
      end else begin
        head[q] = {1'b0, p};
        if (q == Q_TASK) running = p;
      end
      tail[q] = {1'b0, p};
      link[p] = NO_SLOT;
      queued[p] = 1'b1;
      home_queue[p] = q;
    end
  endfunction

  function automatic void make_unready(input logic [PW-1:0] p, output logic removed);
    logic [QW-1:0] q;
    logic [PW:0]   x;
    logic [PW:0]   y;
    logic          found;
    removed = queued[p];
    if (queued[p]) begin
      q = home_queue[p];
      queued[p] = 1'b0;
      if (head[q] == {1'b0, p}) begin
        head[q] = link[p];
        if (head[q] == NO_SLOT) tail[q] = NO_SLOT;
        if (q != Q_TASK || p == running) pick_next();
      end else begin
        x = head[q];
        found = 1'b0;
        for (int n = 0; n < PROC_SLOTS && x < NO_SLOT && !found; n++) begin
          y = link[x[PW-1:0]];
          if (y == {1'b0, p}) begin
            link[x[PW-1:0]] = link[p];
            if (tail[q] == {1'b0, p}) tail[q] = x;
            found = 1'b1;
          end else begin
            x = y;
          end
        end
      end
    end
  endfunction

  function automatic void rotate_users();
    logic [PW:0] h;
    h = head[Q_USER];
    if (h != NO_SLOT) begin
      if (tail[Q_USER] != NO_SLOT) link[tail[Q_USER][PW-1:0]] = h;
      tail[Q_USER] = h;
      head[Q_USER] = link[h[PW-1:0]];
      link[h[PW-1:0]] = NO_SLOT;
      if (head[Q_USER] == NO_SLOT) head[Q_USER] = h;
      pick_next();
    end
  endfunction

  function automatic outcome_t schedule_command(input logic [KW-1:0] k,
                                                input logic [PW-1:0] p);
    outcome_t o;
    logic     removed;
    removed = 1'b0;
    case (k)
      KIND_READY:   make_ready(p);
      KIND_UNREADY: make_unready(p, removed);
      KIND_ROTATE:  rotate_users();
      KIND_PICK:    pick_next();
      default:      pick_next();
    endcase
    o.running = running;
    o.billed = billed;
    o.removed = removed;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      clear_tables();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FIRST_SERVER: first_server = pwdata[TW-1:0];
          REG_FIRST_USER:   first_user = pwdata[TW-1:0];
          REG_IDLE:         idle_proc = pwdata[PW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (due_outcomes.size() == 0) begin
          report_mismatch($sformatf("result item with none due (running %0d)",
                                    running_proc_i));
        end else begin
          want = due_outcomes.pop_front();
          if (running_proc_i !== want.running)
            report_mismatch($sformatf("running_proc %0d, want %0d",
                                      running_proc_i, want.running));
          if (billed_proc_i !== want.billed)
            report_mismatch($sformatf("billed_proc %0d, want %0d",
                                      billed_proc_i, want.billed));
          if (was_queued_i !== want.removed)
            report_mismatch($sformatf("was_queued %0b, want %0b",
                                      was_queued_i, want.removed));
        end
      end
      if (in_valid_i && in_ready_i)
        due_outcomes.push_back(schedule_command(kind_i, proc_index_i));
      due_o = due_outcomes.size();
    end
  end

endmodule

>>> verif/testbench.sv
// Top of the scheduler testbench: clock, reset, command stimulus, register
// writes and the verdict. Depends on tlrq_pkg, scheduler_checker and the block.
module testbench;
  import tlrq_pkg::*;

  localparam int SETTLE      = 70;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 216;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic [KW-1:0] kind_i = KIND_PICK;
  logic [PW-1:0] proc_index_i = '0;
  logic          out_ready_i = 1'b0;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;

  logic          in_ready_o;
  logic          out_valid_o;
  logic [PW-1:0] running_proc_o;
  logic [PW-1:0] billed_proc_o;
  logic          was_queued_o;
  logic [31:0]   prdata;
  logic          pready;

  int fails;
  int due;
  int checked;
  int sent = 0;
  int settings = 0;
  int quiet = 0;
  int tx_max = 19;
  int rx_max = 19;

  three_level_ready_queue_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .proc_index_i  (proc_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .running_proc_o(running_proc_o),
    .billed_proc_o (billed_proc_o),
    .was_queued_o  (was_queued_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  scheduler_checker sched_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .kind_i        (kind_i),
    .proc_index_i  (proc_index_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .running_proc_i(running_proc_o),
    .billed_proc_i (billed_proc_o),
    .was_queued_i  (was_queued_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fails_o       (fails),
    .due_o         (due),
    .checked_o     (checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin : watchdog
    wait (quiet >= QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : result_sink
    int   stall;
    logic hit;
    forever begin
      stall = $urandom_range(rx_max, 0);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        hit = out_valid_o;
        @(posedge clk_i);
      end while (!hit);
    end
  end

  task automatic send_command(input logic [KW-1:0] k, input logic [PW-1:0] p);
    int   gap;
    logic hit;
    gap = $urandom_range(tx_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    proc_index_i <= p;
    do begin
      @(negedge clk_i);
      hit = in_ready_o;
      @(posedge clk_i);
    end while (!hit);
    sent++;
  endtask

  // hold off new commands until every result item has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (due == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    logic hit;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      hit = pready;
      @(posedge clk_i);
    end while (!hit);
  endtask

  task automatic set_scheduler(input int fs, input int fu, input int idle);
    drain_results();
    write_register(REG_FIRST_SERVER, fs);
    write_register(REG_FIRST_USER, fu);
    write_register(REG_IDLE, idle);
    psel <= 1'b0;
    penable <= 1'b0;
    settings++;
  endtask

  task automatic send_random(input int base);
    int            r;
    logic [KW-1:0] k;
    logic [PW-1:0] p;
    r = $urandom_range(99, 0);
    if (r < 40) k = KIND_READY;
    else if (r < 72) k = KIND_UNREADY;
    else if (r < 86) k = KIND_ROTATE;
    else k = KIND_PICK;
    // mostly a narrow window so unready often finds a queued process
    if ($urandom_range(9, 0) < 6) p = PW'(base + $urandom_range(11, 0));
    else p = PW'($urandom_range(63, 0));
    send_command(k, p);
  endtask

  task automatic run_phase(input int fs, input int fu, input int idle, input int n);
    int base;
    set_scheduler(fs, fu, idle);
    base = $urandom_range(52, 0);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_max = ($urandom_range(3, 0) == 0) ? 0 : 19;
        rx_max = ($urandom_range(3, 0) == 0) ? 0 : 19;
        if ($urandom_range(1, 0) == 1) base = $urandom_range(52, 0);
      end
      send_random(base);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: tasks 0..7, servers 8..9, users 10..63
    send_command(KIND_PICK, 6'd0);
    send_command(KIND_UNREADY, 6'd5);
    send_command(KIND_ROTATE, 6'd0);
    send_command(KIND_READY, 6'd12);
    send_command(KIND_READY, 6'd63);
    send_command(KIND_READY, 6'd12);
    send_command(KIND_ROTATE, 6'd0);
    send_command(KIND_READY, 6'd8);
    send_command(KIND_READY, 6'd9);
    send_command(KIND_READY, 6'd3);
    send_command(KIND_READY, 6'd0);
    send_command(KIND_UNREADY, 6'd0);
    send_command(KIND_PICK, 6'd63);
    send_command(KIND_UNREADY, 6'd3);
    send_command(KIND_UNREADY, 6'd9);
    send_command(KIND_UNREADY, 6'd8);
    send_command(KIND_UNREADY, 6'd12);
    send_command(KIND_ROTATE, 6'd0);
    send_command(KIND_READY, 6'd20);
    send_command(KIND_READY, 6'd21);
    send_command(KIND_READY, 6'd22);
    send_command(KIND_READY, 6'd7);
    send_command(KIND_UNREADY, 6'd21);
    drain_results();

    // queued processes stay across the class threshold changes below
    run_phase(0, 0, 63, PHASE_ITEMS);
    run_phase(64, 64, 0, PHASE_ITEMS);
    run_phase(5, 40, 33, PHASE_ITEMS);
    run_phase(40, 20, 17, PHASE_ITEMS);
    run_phase(0, 64, 21, PHASE_ITEMS);
    run_phase(64, 0, 42, PHASE_ITEMS);
    run_phase($urandom_range(64, 0), $urandom_range(64, 0), $urandom_range(63, 0),
              PHASE_ITEMS);
    run_phase($urandom_range(64, 0), $urandom_range(64, 0), $urandom_range(63, 0),
              PHASE_ITEMS);

    drain_results();
    $display("run covered %0d commands and %0d checked results", sent, checked);
    $display("across %0d threshold and idle settings, %0d mismatches", settings, fails);
    if (fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
